// ===== src/ffpra_pkg.sv =====
// Shared types, codes and helpers for the first-fit page region allocator.
`timescale 1ns / 1ps

package ffpra_pkg;

  localparam int PAGE_W = 40;

  typedef enum logic [1:0] {
    MODE_CONTIG  = 2'd0,
    MODE_SCATTER = 2'd1,
    MODE_FREE    = 2'd2,
    MODE_ADD     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OOM     = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_IGNORED = 2'd3
  } status_e;

  // firmware memory types that may be handed out
  localparam logic [3:0] MT_LOADER_CODE  = 4'd1;
  localparam logic [3:0] MT_LOADER_DATA  = 4'd2;
  localparam logic [3:0] MT_BOOT_CODE    = 4'd3;
  localparam logic [3:0] MT_BOOT_DATA    = 4'd4;
  localparam logic [3:0] MT_CONVENTIONAL = 4'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SUM,
    S_TOTAL_CHK,
    S_SCAN,
    S_FIT_SUB,
    S_FIT_ADD
  } state_e;

  typedef struct packed {
    logic [PAGE_W-1:0] first_page;
    logic [PAGE_W-1:0] page_count;
  } region_t;

  typedef struct packed {
    mode_e             mode;
    logic [PAGE_W-1:0] page_count;
    logic [PAGE_W-1:0] region_start;
    logic [3:0]        memory_type;
  } request_t;

  typedef struct packed {
    logic [PAGE_W-1:0] granted_start;
    logic [PAGE_W-1:0] granted_pages;
    status_e           status;
    logic              last;
  } result_t;

  function automatic logic usable_type(input logic [3:0] mt);
    return (mt == MT_LOADER_CODE) || (mt == MT_LOADER_DATA) || (mt == MT_BOOT_CODE) ||
           (mt == MT_BOOT_DATA) || (mt == MT_CONVENTIONAL);
  endfunction

endpackage

// ===== src/ffpra_table.sv =====
// Region table: one write port, one registered read port.
`timescale 1ns / 1ps

module ffpra_table import ffpra_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int IDX_W   = 6
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_addr,
  output region_t          rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  region_t          wr_data
);

  region_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/ffpra_alu.sv =====
// Shared adder/subtractor used by the allocator sequencer.
`timescale 1ns / 1ps

module ffpra_alu #(
  parameter int W = 47
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);

  // for subtraction, carry high means a >= b
  assign {carry, sum} = {1'b0, a} + {1'b0, b ^ {W{sub}}} + {{W{1'b0}}, sub};

endmodule

// ===== src/first_fit_page_region_allocator.sv =====
// Top level: first-fit page region allocator with sequencer and shared adder.
// Usage:
//   A request is taken on a rising edge with start high and busy low. busy stays
//   high while the request is worked on; no other request is taken meanwhile.
//   Results come out on result, each marked by result_valid for one cycle;
//   the final result of a request has last set. The receiver cannot stall.
// Operation (n = regions in use); busy falls at the edge that registers the
// final result, so the next request can be taken from then on:
//   free / add descriptor: one result.
//   contiguous: table scan over the n entries at one entry per cycle.
//   scattered: a summing pass plus an allocation pass;
//   pieces stream out at most one per cycle while the walk runs.
//   The pace is set by the single table read port and the one shared
//   adder, which does every page-count compare, subtract and add.
// Reset:
//   rst (synchronous) empties the table; no clearing pass is run, entries are
//   only read below the fill count.
`timescale 1ns / 1ps

module first_fit_page_region_allocator import ffpra_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     result_valid,
  output result_t  result
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ACC_W = PAGE_W + CNT_W;

  state_e            state, state_next;
  request_t          req;
  logic [CNT_W-1:0]  regions_in_use;
  logic [CNT_W-1:0]  issue_idx;
  logic [IDX_W-1:0]  check_idx;
  logic [IDX_W-1:0]  hit_idx;
  logic              pend;
  logic [PAGE_W-1:0] rest;
  logic [ACC_W-1:0]  total;
  region_t           hit;
  logic [PAGE_W-1:0] diff;

  logic [IDX_W-1:0]  rd_addr;
  region_t           rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  region_t           wr_data;

  logic [ACC_W-1:0]  alu_a, alu_b, alu_sum;
  logic              alu_sub, alu_carry;

  logic              emit;
  result_t           emit_res;

  logic              accept, issue_now, scan_end, covered, scatter, c_zero, table_full;

  ffpra_table #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ffpra_alu #(
    .W (ACC_W)
  ) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign issue_now  = (issue_idx < regions_in_use);
  assign scan_end   = !pend && !issue_now;
  // in the scan the adder forms rest - count: region covers when that is <= 0
  assign covered    = !alu_carry || (alu_sum == '0);
  assign scatter    = (req.mode == MODE_SCATTER);
  assign c_zero     = (rd_data.page_count == '0);
  assign table_full = (regions_in_use == CNT_W'(TABLE_ENTRIES));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (request.mode)
            MODE_CONTIG:  state_next = S_SCAN;
            MODE_SCATTER: state_next = S_SUM;
            default:      state_next = S_APPEND;
          endcase
        end
      end
      S_APPEND:    state_next = S_IDLE;
      S_SUM: begin
        if (scan_end) begin
          state_next = S_TOTAL_CHK;
        end
      end
      S_TOTAL_CHK: state_next = alu_carry ? S_SCAN : S_IDLE;
      S_SCAN: begin
        priority if (pend && covered) begin
          state_next = S_FIT_SUB;
        end else if (scan_end) begin
          state_next = S_IDLE;
        end
      end
      S_FIT_SUB:   state_next = S_FIT_ADD;
      S_FIT_ADD:   state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    rd_addr  = issue_idx[IDX_W-1:0];
    wr_en    = 1'b0;
    wr_addr  = check_idx;
    wr_data  = '0;
    alu_a    = '0;
    alu_b    = '0;
    alu_sub  = 1'b0;
    emit     = 1'b0;
    emit_res = '0;
    unique case (state)
      S_IDLE: ;
      S_APPEND: begin
        emit          = 1'b1;
        emit_res.last = 1'b1;
        priority if (req.mode == MODE_ADD && !usable_type(req.memory_type)) begin
          emit_res.status = STAT_IGNORED;
        end else if (table_full) begin
          emit_res.status = STAT_FULL;
        end else begin
          emit_res.status    = STAT_OK;
          wr_en              = 1'b1;
          wr_addr            = regions_in_use[IDX_W-1:0];
          wr_data.first_page = req.region_start;
          wr_data.page_count = req.page_count;
        end
      end
      S_SUM: begin
        alu_a = total;
        alu_b = ACC_W'(rd_data.page_count);
      end
      S_TOTAL_CHK: begin
        alu_a   = total;
        alu_b   = ACC_W'(req.page_count);
        alu_sub = 1'b1;
        if (!alu_carry) begin
          emit            = 1'b1;
          emit_res.status = STAT_OOM;
          emit_res.last   = 1'b1;
        end
      end
      S_SCAN: begin
        alu_a   = ACC_W'(rest);
        alu_b   = ACC_W'(rd_data.page_count);
        alu_sub = 1'b1;
        priority if (pend && !covered && scatter && !c_zero) begin
          // whole region goes out as a piece and is left empty
          emit                   = 1'b1;
          emit_res.granted_start = rd_data.first_page;
          emit_res.granted_pages = rd_data.page_count;
          emit_res.status        = STAT_OK;
          wr_en                  = 1'b1;
          wr_data.first_page     = rd_data.first_page;
        end else if (scan_end) begin
          emit            = 1'b1;
          emit_res.status = STAT_OOM;
          emit_res.last   = 1'b1;
        end
      end
      S_FIT_SUB: begin
        alu_a   = ACC_W'(hit.page_count);
        alu_b   = ACC_W'(rest);
        alu_sub = 1'b1;
      end
      S_FIT_ADD: begin
        alu_a                  = ACC_W'(hit.first_page);
        alu_b                  = ACC_W'(rest);
        wr_en                  = 1'b1;
        wr_addr                = hit_idx;
        wr_data.first_page     = alu_sum[PAGE_W-1:0];
        wr_data.page_count     = diff;
        emit                   = 1'b1;
        emit_res.granted_start = hit.first_page;
        emit_res.granted_pages = rest;
        emit_res.status        = STAT_OK;
        emit_res.last          = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      regions_in_use <= '0;
      result_valid   <= 1'b0;
      pend           <= 1'b0;
      issue_idx      <= '0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      if (state == S_APPEND && wr_en) begin
        regions_in_use <= regions_in_use + CNT_W'(1);
      end
      if (accept || state == S_TOTAL_CHK) begin
        issue_idx <= '0;
        pend      <= 1'b0;
      end else if (state == S_SUM || state == S_SCAN) begin
        issue_idx <= issue_idx + CNT_W'(issue_now);
        pend      <= issue_now;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    result <= emit_res;
    if (state == S_SUM || state == S_SCAN) begin
      check_idx <= issue_idx[IDX_W-1:0];
    end
    if (accept) begin
      req   <= request;
      rest  <= request.page_count;
      total <= '0;
    end
    if (state == S_SUM && pend) begin
      total <= alu_sum;
    end
    if (state == S_SCAN && pend) begin
      if (covered) begin
        hit     <= rd_data;
        hit_idx <= check_idx;
      end else if (scatter) begin
        rest <= alu_sum[PAGE_W-1:0];
      end
    end
    if (state == S_FIT_SUB) begin
      diff <= alu_sum[PAGE_W-1:0];
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    regions_in_use <= CNT_W'(TABLE_ENTRIES))
    else $error("region count beyond table depth");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != STAT_OK |->
      result.last && result.granted_start == '0 && result.granted_pages == '0)
    else $error("failed transaction carries grant data or is not final");

  a_piece_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> result.granted_pages != '0 && result.status == STAT_OK)
    else $error("empty or failed intermediate piece");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> result_valid && result.last)
    else $error("transaction finished without a final result");

endmodule
